/* rtl/lrl_pkg.sv */
// ----------------------------------------------------------------------------
// LRU recency list package
// Shared sizes, field widths, register codes and cell control type.
// ----------------------------------------------------------------------------
package lrl_pkg;

  // Storage sizes
  localparam int unsigned MaxEntries = 8;
  localparam int unsigned KeyBits    = 16;

  // Internal widths derived from the storage size
  localparam int unsigned PosW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  // Fixed widths of the result fields and the capacity register
  localparam int unsigned HitPosW = 3;
  localparam int unsigned OccW    = 4;
  localparam int unsigned CapW    = 4;
  localparam int unsigned EvKeyW  = 16;

  // Width in which capacity and occupancy are compared
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  localparam logic [CapW-1:0] CapReset = CapW'(5);

  // Configuration port
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0
  } lrl_reg_e;

  // Control handed to each storage cell
  typedef struct packed {
    logic load;    // take the key from the neighbour nearer the front
    logic active;  // position holds a live entry
  } lrl_cell_ctrl_t;

endpackage

/* rtl/lrl_if.sv */
// ----------------------------------------------------------------------------
// LRU recency list channels
// Request channel carrying one key, and response channel carrying one result.
// ----------------------------------------------------------------------------
interface lrl_req_if import lrl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KeyBits-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface lrl_rsp_if import lrl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [HitPosW-1:0] hit_position;
  logic               evicted;
  logic [EvKeyW-1:0]  evicted_key;
  logic [OccW-1:0]    occupancy;

  modport source (output valid, output hit, output hit_position, output evicted,
                  output evicted_key, output occupancy, input ready);
  modport sink   (input valid, input hit, input hit_position, input evicted,
                  input evicted_key, input occupancy, output ready);
endinterface

/* rtl/lrl_cell.sv */
// ----------------------------------------------------------------------------
// LRU recency list cell
// Holds one key of the list, compares it with the incoming key and takes the
// key of its front-side neighbour when the list shifts through it.
// ----------------------------------------------------------------------------
module lrl_cell import lrl_pkg::*; (
  input  logic               clk_i,
  input  lrl_cell_ctrl_t     ctrl_i,
  input  logic [KeyBits-1:0] prev_key_i,
  input  logic [KeyBits-1:0] cmp_key_i,
  output logic [KeyBits-1:0] key_o,
  output logic               match_o
);

  logic [KeyBits-1:0] key_q;
  logic [KeyBits-1:0] key_d;

  assign key_d = ctrl_i.load ? prev_key_i : key_q;

  // Key storage needs no reset: only live positions are ever looked at.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign match_o = ctrl_i.active && (key_q == cmp_key_i);

endmodule

/* rtl/lru_recency_list_top.sv */
// ----------------------------------------------------------------------------
// LRU recency list
// Ordered list of keys, most recently used first, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on req_i, one key each. Every request produces exactly one
//   response on rsp_o: hit flag and position, evicted flag and key, and the
//   number of keys held after the access.
//   All cells compare the request key at once; the first live match wins.
//   In the same cycle the cells from the front down to the hit position (or to
//   the position after the last kept entry on a miss) take the key of their
//   neighbour, and the front cell takes the new key. The response is registered,
//   so it appears in the cycle after the request is accepted, and while the
//   receiver takes each response a new request is accepted in every cycle: one
//   request per cycle, set by the single compare-and-shift pass through the row of cells.
//   If the receiver stalls, the response register holds its contents and
//   req_i.ready stays low until the response is taken; a request may be
//   accepted in the same cycle as the waiting response leaves.
//   Reset empties the list (occupancy zero) and sets capacity to 5. A capacity of 0
//   acts as 1; values above the number of cells act as full size. The user writes
//   capacity over the APB port only while no request is pending; the block leaves this unenforced.
// ----------------------------------------------------------------------------
module lru_recency_list_top import lrl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  // channels
  lrl_req_if.sink           req_i,
  lrl_rsp_if.source         rsp_o
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [CapW-1:0] capacity_q;
  logic [CapW-1:0] capacity_d;
  logic            reg_sel;
  logic            cfg_write;

  // Register i sits at byte address 4*i; the low two bits are ignored.
  assign reg_sel   = (paddr[AddrW-1:2] == (AddrW-2)'(REG_CAPACITY));
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  assign capacity_d = (cfg_write && reg_sel) ? pwdata[CapW-1:0] : capacity_q;
  assign prdata     = reg_sel ? DataW'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapReset;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  // Capacity clamped into the range the row of cells can hold.
  logic [CmpW-1:0] cap_wide;
  logic [CmpW-1:0] cap_eff;

  assign cap_wide = CmpW'(capacity_q);

  always_comb begin
    cap_eff = cap_wide;
    if (cap_wide == '0) begin
      cap_eff = CmpW'(1);
    end
    if (cap_wide > CmpW'(MaxEntries)) begin
      cap_eff = CmpW'(MaxEntries);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and occupancy
  // --------------------------------------------------------------------------
  logic rsp_valid_q;
  logic rsp_valid_d;
  logic req_acc;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_acc     = req_i.valid && req_i.ready;

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;

  // --------------------------------------------------------------------------
  // Row of cells
  // --------------------------------------------------------------------------
  logic [KeyBits-1:0]   cell_key [MaxEntries];
  logic [MaxEntries-1:0] cell_match;
  lrl_cell_ctrl_t       cell_ctrl [MaxEntries];
  logic [CntW-1:0]      shift_len;

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    logic [KeyBits-1:0] prev_key;

    if (g == 0) begin : g_front
      assign prev_key = req_i.key;
    end else begin : g_rest
      assign prev_key = cell_key[g-1];
    end

    assign cell_ctrl[g].load   = req_acc && (CntW'(g) <= shift_len);
    assign cell_ctrl[g].active = (CntW'(g) < count_q);

    lrl_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[g]),
      .prev_key_i (prev_key),
      .cmp_key_i  (req_i.key),
      .key_o      (cell_key[g]),
      .match_o    (cell_match[g])
    );
  end

  // First live match, nearest the front.
  logic            hit;
  logic [PosW-1:0] hit_pos;

  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        hit     = 1'b1;
        hit_pos = PosW'(i);
      end
    end
  end

  // Miss handling: evict the tail when the list has reached capacity.
  logic            full;
  logic            evict;
  logic [CntW-1:0] count_m1;
  logic [PosW-1:0] tail_idx;
  logic [CntW-1:0] kept;

  assign full     = (CmpW'(count_q) >= cap_eff);
  assign evict    = !hit && full && (count_q != '0);
  assign count_m1 = count_q - CntW'(1);
  assign tail_idx = count_m1[PosW-1:0];
  assign kept     = evict ? count_m1 : count_q;

  always_comb begin
    if (hit) begin
      shift_len = CntW'(hit_pos);
      count_d   = count_q;
    end else begin
      shift_len = kept;
      count_d   = kept + CntW'(1);
    end
    if (!req_acc) begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // --------------------------------------------------------------------------
  // Response register
  // --------------------------------------------------------------------------
  logic                       hit_q;
  logic [HitPosW-1:0]         hit_pos_q;
  logic                       evicted_q;
  logic [EvKeyW-1:0]          ev_key_q;
  logic [OccW-1:0]            occ_q;
  logic [PosW+HitPosW-1:0]    pos_ext;
  logic [CntW+OccW-1:0]       occ_ext;
  logic [KeyBits+EvKeyW-1:0]  ev_ext;

  assign pos_ext = (PosW + HitPosW)'(hit_pos);
  assign occ_ext = (CntW + OccW)'(count_d);
  assign ev_ext  = (KeyBits + EvKeyW)'(cell_key[tail_idx]);

  assign rsp_valid_d = req_acc || (rsp_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      hit_q     <= hit;
      hit_pos_q <= hit ? pos_ext[HitPosW-1:0] : '0;
      evicted_q <= evict;
      ev_key_q  <= evict ? ev_ext[EvKeyW-1:0] : '0;
      occ_q     <= occ_ext[OccW-1:0];
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.hit          = hit_q;
  assign rsp_o.hit_position = hit_pos_q;
  assign rsp_o.evicted      = evicted_q;
  assign rsp_o.evicted_key  = ev_key_q;
  assign rsp_o.occupancy    = occ_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("occupancy beyond the number of cells");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_acc |=> $stable(count_q))
    else $error("occupancy changed without a request");

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> rsp_o.valid)
    else $error("accepted request gave no response");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.evicted))
    else $error("hit and eviction in the same response");

  a_hit_is_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> (cell_match[hit_pos] && (CntW'(hit_pos) < count_q)))
    else $error("hit position does not point at a live match");
`endif

endmodule
